// File: design/psq_pkg.sv
`timescale 1ns / 1ps

package psq_pkg;

    localparam int DEPTH     = 16;
    localparam int ELEM_BITS = 32;
    localparam int PRIO_BITS = 8;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [ELEM_BITS-1:0] elem;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    // broadcast to every cell of the row
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_cell_ctl;

endpackage

// File: design/psq_if.sv
`timescale 1ns / 1ps

interface psq_in_if;
    import psq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [ELEM_BITS-1:0] elem_in;
    logic [PRIO_BITS-1:0] prio_in;

    modport source (output valid, output cmd, output elem_in, output prio_in, input ready);
    modport sink   (input valid, input cmd, input elem_in, input prio_in, output ready);
endinterface

interface psq_out_if;
    import psq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ELEM_BITS-1:0] top_elem;
    logic [PRIO_BITS-1:0] top_prio;
    logic [CNT_BITS-1:0]  count;
    logic                 is_empty;
    logic                 is_full;
    logic [1:0]           status;

    modport source (output valid, output top_elem, output top_prio, output count,
                    output is_empty, output is_full, output status, input ready);
    modport sink   (input valid, input top_elem, input top_prio, input count,
                    input is_empty, input is_full, input status, output ready);
endinterface

// File: design/psq_cell.sv
`timescale 1ns / 1ps

module psq_cell (
    input  logic               i_clk,
    input  psq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  psq_pkg::t_entry    i_left,
    input  logic               i_left_gt,
    input  psq_pkg::t_entry    i_right,
    output psq_pkg::t_entry    o_entry,
    output psq_pkg::t_entry    o_next,
    output logic               o_gt
);
    import psq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // stored entry outranks the incoming one: it stays ahead of the insert point
    assign o_gt = i_valid && (r_entry.prio > i_ctl.entry.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (!o_gt) begin
                n_entry = i_left_gt ? i_ctl.entry : i_left;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;

endmodule

// File: design/priority_stack.sv
`timescale 1ns / 1ps

// Bounded priority stack, highest priority on top, equal priorities leave
// last in first out.
// i_in carries one command per transaction: push (elem_in, prio_in), pop of
// the top entry, or clear. Command code 3 changes nothing and reports state.
// o_out returns exactly one result per command: top element and priority
// (zero when empty), count, empty and full flags, and a status that flags a
// refused push on a full store or a refused pop on an empty one.
// Storage is a row of DEPTH cells; every cell compares its priority with the
// pushed one at once and shifts toward its neighbor. The result sits in the
// output register the cycle after the transaction, and one command per cycle
// is taken while o_out.ready is high. When the receiver stalls, the waiting
// result holds and i_in.ready drops until it is taken.
// Reset empties the store (count zero) and drops the output valid; the cell
// contents are not cleared, only entries below the count are ever read.

module priority_stack (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psq_in_if.sink    i_in,
    psq_out_if.source o_out
);
    import psq_pkg::*;

    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic                 r_out_valid;
    logic [ELEM_BITS-1:0] r_top_elem;
    logic [PRIO_BITS-1:0] r_top_prio;
    logic [CNT_BITS-1:0]  r_out_count;
    t_status              r_status;
    t_status              n_status;

    logic      accept;
    logic      full;
    logic      empty;
    t_cell_ctl ctl;

    t_entry    cell_entry [DEPTH];
    t_entry    cell_next  [DEPTH];
    logic      cell_gt    [DEPTH];

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_BITS'(DEPTH));
    assign empty      = (r_count == '0);

    always_comb begin
        n_count    = r_count;
        n_status   = ST_DONE;
        ctl.push   = 1'b0;
        ctl.pop    = 1'b0;
        ctl.entry.elem = i_in.elem_in;
        ctl.entry.prio = i_in.prio_in;
        if (accept) begin
            case (t_cmd'(i_in.cmd))
                CMD_PUSH: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.push = 1'b1;
                        n_count  = r_count + CNT_BITS'(1);
                    end
                end
                CMD_POP: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        ctl.pop = 1'b1;
                        n_count = r_count - CNT_BITS'(1);
                    end
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_entry left;
        t_entry right;
        logic   left_gt;

        if (i == 0) begin : g_head
            assign left    = cell_entry[i];
            assign left_gt = 1'b1;
        end else begin : g_body
            assign left    = cell_entry[i-1];
            assign left_gt = cell_gt[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right = cell_entry[i];
        end else begin : g_inner
            assign right = cell_entry[i+1];
        end

        psq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_valid   (CNT_BITS'(i) < r_count),
            .i_left    (left),
            .i_left_gt (left_gt),
            .i_right   (right),
            .o_entry   (cell_entry[i]),
            .o_next    (cell_next[i]),
            .o_gt      (cell_gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top_elem  <= (n_count == '0) ? '0 : cell_next[0].elem;
            r_top_prio  <= (n_count == '0) ? '0 : cell_next[0].prio;
            r_out_count <= n_count;
            r_status    <= n_status;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.top_elem = r_top_elem;
    assign o_out.top_prio = r_top_prio;
    assign o_out.count    = r_out_count;
    assign o_out.is_empty = (r_out_count == '0);
    assign o_out.is_full  = (r_out_count == CNT_BITS'(DEPTH));
    assign o_out.status   = r_status;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("occupancy beyond depth");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.cmd == CMD_PUSH) && full)
        |=> (r_count == CNT_BITS'(DEPTH)) && (r_status == ST_FULL))
        else $error("push on full store changed occupancy");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.cmd == CMD_POP) && !empty)
        |=> (r_count == $past(r_count) - CNT_BITS'(1)))
        else $error("pop did not drop occupancy by one");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_out.count == r_count))
        else $error("reported count differs from occupancy");
`endif

endmodule
